[rtl/core/rank_weighted_slot_picker_defines.svh]
// assertion macros shared by the slot picker rtl
`ifndef RANK_WEIGHTED_SLOT_PICKER_DEFINES_SVH
`define RANK_WEIGHTED_SLOT_PICKER_DEFINES_SVH

// same-cycle implication, checked on every rising edge outside reset
`define RWSP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked on every rising edge outside reset
`define RWSP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/core/rwsp_pkg.sv]
// types and constants of the rank weighted slot picker
`default_nettype none

package rwsp_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int IDX_W       = 4;
  localparam int VAL_W       = 16;
  localparam int DRAW_W      = 14;
  localparam int CNT_W       = 5;   // candidate count, 0..16
  localparam int SLOT_W      = 5;   // slot number before range check, 0..31
  localparam int LHS_W       = 20;  // 2*c*draw
  localparam int ACC_W       = 22;  // signed cumulative weight terms
  localparam int PAIR_W      = 8;   // c*(c-1)
  localparam int STEP_W      = 12;  // 200*c

  localparam int SCALE_BASE  = 20000;
  localparam int WEIGHT_STEP = 100;

  localparam logic KIND_WRITE  = 1'b0;
  localparam logic KIND_SELECT = 1'b1;

  typedef struct packed {
    logic              go;
    logic [CNT_W-1:0]  cnt;
    logic [DRAW_W-1:0] draw;
  } th_req_t;

  typedef struct packed {
    logic             done;
    logic [CNT_W-1:0] rank;
  } th_resp_t;

endpackage

`default_nettype wire

[rtl/core/rwsp_thresh.sv]
// threshold rank search: steps the cumulative weight one rank a cycle
`default_nettype none

module rwsp_thresh import rwsp_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  th_req_t  req,
  output th_resp_t resp
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SETUP,
    ST_SCALE,
    ST_SCAN
  } state_t;

  localparam int STEP2 = 2 * WEIGHT_STEP;

  state_t                   state;
  logic [CNT_W-1:0]         cnt;
  logic [DRAW_W-1:0]        draw;
  logic [CNT_W-1:0]         k;
  logic [LHS_W-1:0]         lhs;
  logic [PAIR_W-1:0]        pair;
  logic [STEP_W-1:0]        step;
  logic signed [ACC_W-1:0]  rhs;
  logic signed [ACC_W-1:0]  inc;

  logic [LHS_W-1:0]         lhs_mul;
  logic [ACC_W-1:0]         scale_v;
  logic                     reached;

  assign lhs_mul = LHS_W'(cnt) * LHS_W'(draw);
  assign scale_v = ACC_W'(SCALE_BASE) + ACC_W'(pair) * ACC_W'(WEIGHT_STEP);
  assign reached = $signed({2'b00, lhs}) <= rhs;

  always_ff @(posedge clk) begin
    resp.done <= 1'b0;
    if (rst) begin
      state     <= ST_IDLE;
      resp.rank <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (req.go) begin
            cnt   <= req.cnt;
            draw  <= req.draw;
            state <= ST_SETUP;
          end
        end
        ST_SETUP: begin
          lhs   <= {lhs_mul[LHS_W-2:0], 1'b0};
          pair  <= PAIR_W'(cnt) * PAIR_W'(cnt - 1'b1);
          step  <= STEP_W'(cnt) * STEP_W'(STEP2);
          state <= ST_SCALE;
        end
        ST_SCALE: begin
          rhs   <= scale_v;
          inc   <= scale_v - ACC_W'(step);
          k     <= CNT_W'(1);
          state <= ST_SCAN;
        end
        ST_SCAN: begin
          // past the last rank the last rank is taken, so both exits give k-1
          if (reached || k == cnt) begin
            resp.done <= 1'b1;
            resp.rank <= k - 1'b1;
            state     <= ST_IDLE;
          end else begin
            rhs <= rhs + inc;
            inc <= inc - ACC_W'(step);
            k   <= k + 1'b1;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

[rtl/core/rank_weighted_slot_picker.sv]
// top level of the rank weighted slot picker
`default_nettype none

`include "rank_weighted_slot_picker_defines.svh"

// Linear-ranking slot picker over a 16-entry table of remaining-packet counts
// (all zero after reset). An item is transferred on a rising edge with start
// high and busy low; kind selects a table write or a selection. Every item
// gives exactly one result, shown for a single cycle with done high; the
// receiver cannot stall it, so it must take found/chosen_index on that cycle.
// A write item updates the table and raises done on the next cycle without
// going busy, so another item may follow right away. A selection is
// sequential and holds busy high: a pass over the whole table counts the
// occupied slots of both halves, the threshold unit finds the target rank
// with one adder/compare, then one table read per cycle locates the
// candidate holding that rank: each occupied slot of the half tried is
// ranked against every slot of that half, stopping at the match. When both
// halves are empty the result comes after the count pass alone.
module rank_weighted_slot_picker import rwsp_pkg::*; #(
  parameter int SLOTS_PER_HALF = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic              kind,
  input  logic [IDX_W-1:0]  entry_index,
  input  logic [VAL_W-1:0]  entry_value,
  input  logic              half_choice,
  input  logic [DRAW_W-1:0] random_draw,
  output logic              done,
  output logic              found,
  output logic [IDX_W-1:0]  chosen_index
);

  localparam int IW = $clog2(SLOTS_PER_HALF);
  localparam logic [SLOT_W-1:0] HALF_BASE = SLOT_W'(SLOTS_PER_HALF);
  localparam logic [IW-1:0]     LAST_POS  = IW'(SLOTS_PER_HALF - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_COUNT,
    ST_TH,
    ST_PICK,
    ST_RANK
  } state_t;

  state_t            state;
  logic [VAL_W-1:0]  slot_count [TABLE_DEPTH];

  logic [IDX_W-1:0]  t;          // count pass address
  logic [CNT_W-1:0]  cnt0;
  logic [CNT_W-1:0]  cnt1;
  logic              half_req;
  logic              half_sel;
  logic [DRAW_W-1:0] draw_q;
  logic [CNT_W-1:0]  cnt_sel;
  logic [CNT_W-1:0]  rstar;      // target rank from the threshold unit
  logic [IW-1:0]     j;          // candidate position in the half
  logic [IW-1:0]     i;          // compare position in the half
  logic [VAL_W-1:0]  jval;
  logic [CNT_W-1:0]  rank;
  logic              th_go;

  th_req_t           th_req;
  th_resp_t          th_resp;

  logic [SLOT_W-1:0] base;
  logic [SLOT_W-1:0] cur_slot;
  logic [SLOT_W-1:0] j_slot;
  logic [IDX_W-1:0]  rd_addr;
  logic [VAL_W-1:0]  rd_val;
  logic [VAL_W-1:0]  cur_val;
  logic              hit0;
  logic              hit1;
  logic [CNT_W-1:0]  cnt0_next;
  logic [CNT_W-1:0]  cnt1_next;
  logic              rank_hit;
  logic [CNT_W-1:0]  rank_next;

  // single read port: count pass walks the table, later passes walk one half
  assign base     = half_sel ? HALF_BASE : '0;
  assign cur_slot = base + SLOT_W'((state == ST_PICK) ? j : i);
  assign j_slot   = base + SLOT_W'(j);
  assign rd_addr  = (state == ST_COUNT) ? t : cur_slot[IDX_W-1:0];
  assign rd_val   = slot_count[rd_addr];
  // slots beyond the table read as empty
  assign cur_val  = (state == ST_COUNT || !cur_slot[SLOT_W-1]) ? rd_val : '0;

  assign hit0      = (rd_val != '0) && (int'(t) < SLOTS_PER_HALF);
  assign hit1      = (rd_val != '0) && (int'(t) >= SLOTS_PER_HALF)
                     && (int'(t) < 2 * SLOTS_PER_HALF);
  assign cnt0_next = cnt0 + CNT_W'(hit0);
  assign cnt1_next = cnt1 + CNT_W'(hit1);

  // stable order: smaller count first, equal counts by slot order
  assign rank_hit  = (cur_val != '0)
                     && ((cur_val < jval) || ((cur_val == jval) && (i < j)));
  assign rank_next = rank + CNT_W'(rank_hit);

  assign busy = (state != ST_IDLE);

  assign th_req.go   = th_go;
  assign th_req.cnt  = cnt_sel;
  assign th_req.draw = draw_q;

  rwsp_thresh u_thresh (
    .clk  (clk),
    .rst  (rst),
    .req  (th_req),
    .resp (th_resp)
  );

  always_ff @(posedge clk) begin
    done  <= 1'b0;
    th_go <= 1'b0;
    if (rst) begin
      state        <= ST_IDLE;
      found        <= 1'b0;
      chosen_index <= '0;
      for (int n = 0; n < TABLE_DEPTH; n++) begin
        slot_count[n] <= '0;
      end
    end else begin
      case (state)
        ST_IDLE: begin
          if (start) begin
            if (kind == KIND_WRITE) begin
              slot_count[entry_index] <= entry_value;
              done         <= 1'b1;
              found        <= 1'b0;
              chosen_index <= '0;
            end else begin
              half_req <= half_choice;
              draw_q   <= random_draw;
              t        <= '0;
              cnt0     <= '0;
              cnt1     <= '0;
              state    <= ST_COUNT;
            end
          end
        end
        ST_COUNT: begin
          cnt0 <= cnt0_next;
          cnt1 <= cnt1_next;
          t    <= t + 1'b1;
          if (t == IDX_W'(TABLE_DEPTH - 1)) begin
            // fall back to the other half when the requested one is empty
            if ((half_req ? cnt1_next : cnt0_next) != '0) begin
              half_sel <= half_req;
              cnt_sel  <= half_req ? cnt1_next : cnt0_next;
              th_go    <= 1'b1;
              state    <= ST_TH;
            end else if ((half_req ? cnt0_next : cnt1_next) != '0) begin
              half_sel <= !half_req;
              cnt_sel  <= half_req ? cnt0_next : cnt1_next;
              th_go    <= 1'b1;
              state    <= ST_TH;
            end else begin
              done         <= 1'b1;
              found        <= 1'b0;
              chosen_index <= '0;
              state        <= ST_IDLE;
            end
          end
        end
        ST_TH: begin
          if (th_resp.done) begin
            rstar <= th_resp.rank;
            j     <= '0;
            state <= ST_PICK;
          end
        end
        ST_PICK: begin
          if (cur_val != '0) begin
            jval  <= cur_val;
            i     <= '0;
            rank  <= '0;
            state <= ST_RANK;
          end else begin
            j <= j + 1'b1;
          end
        end
        ST_RANK: begin
          if (i == LAST_POS) begin
            if (rank_next == rstar) begin
              done         <= 1'b1;
              found        <= 1'b1;
              chosen_index <= j_slot[IDX_W-1:0];
              state        <= ST_IDLE;
            end else begin
              j     <= j + 1'b1;
              state <= ST_PICK;
            end
          end else begin
            i    <= i + 1'b1;
            rank <= rank_next;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `RWSP_ASSERT_NOW(a_empty_index_zero, done && !found, chosen_index == '0, "index set without a pick")
  `RWSP_ASSERT_NEXT(a_select_goes_busy, start && !busy && kind == KIND_SELECT, busy, "selection did not start")
  `RWSP_ASSERT_NEXT(a_write_acks, start && !busy && kind == KIND_WRITE, done && !found, "write not acknowledged")
  `RWSP_ASSERT_NOW(a_rank_in_range, th_resp.done, th_resp.rank < cnt_sel, "target rank beyond candidates")

endmodule

`default_nettype wire

[sim/rank_weighted_slot_picker_tb.sv]
// self-checking testbench for the rank weighted slot picker
`timescale 1ns / 1ps

module rank_weighted_slot_picker_tb;
  import rwsp_pkg::*;

  localparam int  SLOTS_PER_HALF = 8;
  localparam int  RANDOM_ITEMS   = 1550;
  localparam int  CYCLE_LIMIT    = 1000000;
  localparam int  SETTLE_CYCLES  = 150;    // wait after the last result before the final check
  localparam int  MAX_GAP        = 8;
  localparam int  DRAW_FULL      = 10000;  // draw that maps to a threshold of one
  localparam int  DRAW_MAX       = (1 << DRAW_W) - 1;
  localparam longint RANK_BASE   = 20000;  // threshold test scaled by 20000*c
  localparam longint RANK_STEP   = 100;    // weight drop per rank, same scale

  // one command as the sender sees it, plus its pacing
  typedef struct {
    logic              kind;
    logic [IDX_W-1:0]  idx;
    logic [VAL_W-1:0]  val;
    logic              half;
    logic [DRAW_W-1:0] draw;
    int                gap;     // idle cycles before the command is offered
    bit                drain;   // hold off until every result is back
  } slot_cmd_t;

  typedef struct {
    logic             found;
    logic [IDX_W-1:0] slot;
  } slot_pick_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  logic              busy;
  logic              kind = KIND_WRITE;
  logic [IDX_W-1:0]  entry_index = '0;
  logic [VAL_W-1:0]  entry_value = '0;
  logic              half_choice = 1'b0;
  logic [DRAW_W-1:0] random_draw = '0;
  logic              done;
  logic              found;
  logic [IDX_W-1:0]  chosen_index;

  rank_weighted_slot_picker #(
    .SLOTS_PER_HALF(SLOTS_PER_HALF)
  ) u_dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .kind        (kind),
    .entry_index (entry_index),
    .entry_value (entry_value),
    .half_choice (half_choice),
    .random_draw (random_draw),
    .done        (done),
    .found       (found),
    .chosen_index(chosen_index)
  );

  always #1 clk = ~clk;

  // shadow of the remaining-packet table, updated on every accepted write
  logic [VAL_W-1:0] slot_count [TABLE_DEPTH];

  slot_cmd_t  cmd_backlog[$];      // commands not yet offered
  slot_pick_t expected_picks[$];   // one per accepted command, oldest first

  slot_cmd_t  cur_cmd;
  bit         cur_loaded = 1'b0;
  int         gap_left   = 0;
  int         total_cmds = 0;
  int         accepted_cnt = 0;    // updated nonblocking, read by the drain hold
  int         checked_cnt  = 0;    // same
  int         cycle_cnt    = 0;
  int         err_cnt      = 0;
  int         n_writes = 0, n_selects = 0, n_over = 0, n_found = 0, n_empty = 0;

  // ---------------------------------------------------------------------------
  // prediction
  // ---------------------------------------------------------------------------

  // linear ranking: gather nonzero counts of the half tried (falling back to
  // the other half), stable-sort ascending, then take the first rank whose
  // cumulative weight reaches draw/10000; the comparison is done in integers
  function automatic slot_pick_t pick_ranked_slot(logic half, logic [DRAW_W-1:0] draw);
    slot_pick_t       res;
    logic [IDX_W-1:0] cand_slot [TABLE_DEPTH];
    logic [VAL_W-1:0] cand_cnt  [TABLE_DEPTH];
    logic [IDX_W-1:0] hold_slot;
    logic [VAL_W-1:0] hold_cnt;
    int               c, h, s, j;
    longint           lhs, scale, k;
    res.found = 1'b0;
    res.slot  = '0;
    c = 0;
    for (int attempt = 0; attempt < 2 && c == 0; attempt++) begin
      h = int'(half) ^ attempt;
      for (int i = 0; i < SLOTS_PER_HALF; i++) begin
        s = h * SLOTS_PER_HALF + i;
        // slots of a half that fall past the table are treated as empty
        if (s < TABLE_DEPTH && slot_count[s] != '0) begin
          cand_slot[c] = IDX_W'(s);
          cand_cnt[c]  = slot_count[s];
          c++;
        end
      end
    end
    if (c == 0)
      return res;
    // insertion sort keeps equal counts in slot order
    for (int i = 1; i < c; i++) begin
      hold_slot = cand_slot[i];
      hold_cnt  = cand_cnt[i];
      j = i - 1;
      while (j >= 0 && cand_cnt[j] > hold_cnt) begin
        cand_slot[j+1] = cand_slot[j];
        cand_cnt[j+1]  = cand_cnt[j];
        j--;
      end
      cand_slot[j+1] = hold_slot;
      cand_cnt[j+1]  = hold_cnt;
    end
    res.found = 1'b1;
    // a draw above 10000 reaches no rank, so the last one stands
    res.slot  = cand_slot[c-1];
    lhs   = 2 * longint'(c) * longint'(draw);
    scale = RANK_BASE + RANK_STEP * longint'(c) * longint'(c - 1);
    for (int n = 0; n < c; n++) begin
      k = longint'(n + 1);
      if (lhs <= k * scale - RANK_STEP * longint'(c) * k * (k - 1)) begin
        res.slot = cand_slot[n];
        return res;
      end
    end
    return res;
  endfunction

  // applies one accepted command to the shadow table and gives its result
  function automatic slot_pick_t apply_slot_cmd(slot_cmd_t cmd);
    slot_pick_t res;
    res.found = 1'b0;
    res.slot  = '0;
    if (cmd.kind == KIND_WRITE) begin
      slot_count[cmd.idx] = cmd.val;
      n_writes++;
    end else begin
      res = pick_ranked_slot(cmd.half, cmd.draw);
      n_selects++;
      if (int'(cmd.draw) > DRAW_FULL)
        n_over++;
    end
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // driver: offers backlog commands with random idle gaps; a transfer happens
  // on an edge where start is high and busy is low
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : cmd_driver
    logic next_start;
    bit   fire;
    int   taken;
    next_start = start;
    fire       = 1'b0;
    if (rst) begin
      next_start = 1'b0;
    end else begin
      fire  = start && !busy;
      taken = accepted_cnt + int'(fire);
      if (fire) begin
        expected_picks.push_back(apply_slot_cmd(cur_cmd));
        accepted_cnt <= accepted_cnt + 1;
        cur_loaded = 1'b0;
        next_start = 1'b0;
      end
      if (!cur_loaded && cmd_backlog.size() != 0) begin
        cur_cmd    = cmd_backlog.pop_front();
        gap_left   = cur_cmd.gap;
        cur_loaded = 1'b1;
      end
      // start stays high across back-to-back transfers: one assignment only
      if (cur_loaded && !next_start) begin
        if (gap_left != 0) begin
          gap_left--;
        end else if (!cur_cmd.drain || taken == checked_cnt) begin
          next_start  = 1'b1;
          kind        <= cur_cmd.kind;
          entry_index <= cur_cmd.idx;
          entry_value <= cur_cmd.val;
          half_choice <= cur_cmd.half;
          random_draw <= cur_cmd.draw;
        end
      end
    end
    start <= next_start;
  end

  // ---------------------------------------------------------------------------
  // monitor: a result is valid for the single cycle that done is high
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : pick_monitor
    slot_pick_t want;
    if (!rst && done) begin
      checked_cnt <= checked_cnt + 1;
      if (expected_picks.size() == 0) begin
        $error("result with nothing pending: found=%0d chosen_index=%0d",
               found, chosen_index);
        err_cnt++;
      end else begin
        want = expected_picks.pop_front();
        if (found !== want.found) begin
          $error("found: expected %0d, got %0d", want.found, found);
          err_cnt++;
        end
        if (chosen_index !== want.slot) begin
          $error("chosen_index: expected %0d, got %0d", want.slot, chosen_index);
          err_cnt++;
        end
        if (want.found)
          n_found++;
        else
          n_empty++;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d of %0d transfers done",
               cycle_cnt, accepted_cnt, total_cmds);
      $display("FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  function automatic void queue_cmd(logic k, int idx, int val, logic half, int draw,
                                    int gap, bit drain);
    slot_cmd_t cmd;
    cmd.kind  = k;
    cmd.idx   = IDX_W'(idx);
    cmd.val   = VAL_W'(val);
    cmd.half  = half;
    cmd.draw  = DRAW_W'(draw);
    cmd.gap   = gap;
    cmd.drain = drain;
    cmd_backlog.push_back(cmd);
    total_cmds++;
  endfunction

  // counts lean on zero and small values so halves empty out and ties show up
  function automatic int rand_count();
    int r;
    r = $urandom_range(0, 99);
    if (r < 25) return 0;
    if (r < 50) return $urandom_range(1, 3);
    if (r < 55) return (1 << VAL_W) - 1;
    return $urandom_range(1, (1 << VAL_W) - 1);
  endfunction

  function automatic int rand_draw();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8)  return $urandom_range(DRAW_FULL + 1, DRAW_MAX);
    if (r < 11) return DRAW_FULL;
    if (r < 14) return 0;
    return $urandom_range(0, DRAW_FULL);
  endfunction

  initial begin : stimulus
    int  made, seg, h, gap;
    bit  burst;

    // directed: empty table, single candidates, fallback, ties, draw extremes
    queue_cmd(KIND_SELECT, 7, 'hFFFF, 1'b0, 5000, 0, 1'b0);   // both halves empty
    queue_cmd(KIND_SELECT, 0, 0, 1'b1, 0, 0, 1'b0);
    queue_cmd(KIND_WRITE, 3, 'hFFFF, 1'b1, DRAW_MAX, 0, 1'b0);  // select fields ignored
    queue_cmd(KIND_SELECT, 15, 1, 1'b1, DRAW_FULL, 0, 1'b0);    // falls back to low half
    queue_cmd(KIND_WRITE, 12, 1, 1'b0, 0, 0, 1'b0);
    queue_cmd(KIND_SELECT, 0, 0, 1'b1, 0, 0, 1'b0);
    queue_cmd(KIND_WRITE, 0, 5, 1'b0, 0, 0, 1'b0);              // three equal counts
    queue_cmd(KIND_WRITE, 1, 5, 1'b0, 0, 0, 1'b0);
    queue_cmd(KIND_WRITE, 2, 5, 1'b0, 0, 0, 1'b0);
    queue_cmd(KIND_WRITE, 4, 1, 1'b0, 0, 0, 1'b0);
    queue_cmd(KIND_WRITE, 7, 'h8000, 1'b0, 0, 0, 1'b0);
    queue_cmd(KIND_SELECT, 0, 0, 1'b0, 0, 0, 1'b0);
    queue_cmd(KIND_SELECT, 0, 0, 1'b0, 1, 0, 1'b0);
    queue_cmd(KIND_SELECT, 0, 0, 1'b0, 3400, 0, 1'b0);
    queue_cmd(KIND_SELECT, 0, 0, 1'b0, 9999, 0, 1'b0);
    queue_cmd(KIND_SELECT, 0, 0, 1'b0, DRAW_FULL, 0, 1'b0);
    queue_cmd(KIND_SELECT, 0, 0, 1'b0, DRAW_MAX, 0, 1'b0);      // beyond the last rank
    queue_cmd(KIND_WRITE, 12, 0, 1'b0, 0, 0, 1'b1);             // clear, after a full drain
    queue_cmd(KIND_SELECT, 0, 0, 1'b1, 3000, 0, 1'b0);          // high half empty again
    queue_cmd(KIND_WRITE, 15, 'hFFFF, 1'b0, 0, 0, 1'b0);
    queue_cmd(KIND_WRITE, 8, 'hAAAA, 1'b0, 0, 0, 1'b0);
    queue_cmd(KIND_WRITE, 9, 'h5555, 1'b0, 0, 0, 1'b0);
    queue_cmd(KIND_SELECT, 0, 0, 1'b1, DRAW_FULL, 0, 1'b0);
    queue_cmd(KIND_SELECT, 0, 0, 1'b1, 0, 0, 1'b0);

    // random: single commands mixed with sequences that fill or clear a half
    made  = 0;
    burst = 1'b0;
    while (made < RANDOM_ITEMS) begin
      if (made % 64 == 0)
        burst = ($urandom_range(0, 3) == 0);   // stretches with no idling
      seg = $urandom_range(0, 19);
      h   = $urandom_range(0, 1);
      if (seg < 2) begin
        // fill (or with seg 1, clear) a whole half
        for (int i = 0; i < SLOTS_PER_HALF; i++) begin
          gap = burst ? 0 : $urandom_range(0, MAX_GAP);
          queue_cmd(KIND_WRITE, h * SLOTS_PER_HALF + i,
                    (seg == 0) ? $urandom_range(1, (1 << VAL_W) - 1) : 0,
                    1'($urandom_range(0, 1)), $urandom_range(0, DRAW_MAX), gap, 1'b0);
          made++;
        end
      end else begin
        gap = burst ? 0 : $urandom_range(0, MAX_GAP);
        if ($urandom_range(0, 99) < 55)
          queue_cmd(KIND_SELECT, $urandom_range(0, TABLE_DEPTH - 1),
                    $urandom_range(0, (1 << VAL_W) - 1), 1'(h), rand_draw(), gap,
                    (made % 100) == 99);
        else
          queue_cmd(KIND_WRITE, $urandom_range(0, TABLE_DEPTH - 1), rand_count(), 1'(h),
                    $urandom_range(0, DRAW_MAX), gap, (made % 100) == 99);
        made++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // reset, end of run
  // ---------------------------------------------------------------------------
  initial begin : run_control
    for (int i = 0; i < TABLE_DEPTH; i++)
      slot_count[i] = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    // every command transferred and every result back
    while (accepted_cnt != total_cmds || checked_cnt != accepted_cnt || total_cmds == 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
    if (expected_picks.size() != 0) begin
      $error("%0d expected results never came", expected_picks.size());
      err_cnt++;
    end
    $display("covered %0d table writes and %0d selections (%0d with draw past 10000)",
             n_writes, n_selects, n_over);
    $display("selections: %0d picked a slot, %0d found both halves empty; %0d mismatches",
             n_found, n_empty - n_writes, err_cnt);
    if (err_cnt == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
